// ===== rtl/fmrc_pkg.sv =====
// Package for the first-match rule classifier: types, codes and defaults.
package fmrc_pkg;

  localparam int RULE_DEPTH_DEF        = 16;
  localparam int SERVICES_PER_RULE_DEF = 4;
  localparam int APPS_PER_RULE_DEF     = 4;

  typedef enum logic [1:0] {
    ACT_EVAL = 2'd0,
    ACT_HDR  = 2'd1,
    ACT_SVC  = 2'd2,
    ACT_APP  = 2'd3
  } act_t;

  localparam logic [1:0] ZONE_ANY   = 2'd3;
  localparam logic [1:0] VERD_ALLOW = 2'd0;
  localparam logic [1:0] VERD_DENY  = 2'd1;
  localparam logic [1:0] VERD_DROP  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_HOLD = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0] from_zone;
    logic [1:0] to_zone;
    logic [1:0] verdict;
    logic [2:0] svc_count;
    logic [2:0] app_count;
  } hdr_t;

  typedef struct packed {
    logic [7:0]  proto;
    logic [15:0] port;
  } svc_t;

endpackage

// ===== rtl/fmrc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fmrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/first_match_rule_classifier_unit.sv =====
// Top level of the first-match rule classifier: rule tables, scan sequencer, result register.
//
// Write requests (header, service slot, application slot) are written to the tables when
// accepted. An evaluate request scans n rules, n being rule_count limited to RULE_DEPTH,
// over K slots each, K being the larger of SERVICES_PER_RULE and APPS_PER_RULE; a hit
// ends the scan early, after the rule that matched. The one compare unit takes one service
// slot and one application slot of the current rule per cycle from the slot RAMs. The
// block takes no request while an evaluation runs, but takes new requests while a result
// still waits at the output. rule_count is written through cfg_wr_en; the user must do
// so only while the block is idle, as the block itself does not enforce it.
module first_match_rule_classifier_unit #(
  parameter int RULE_DEPTH        = fmrc_pkg::RULE_DEPTH_DEF,
  parameter int SERVICES_PER_RULE = fmrc_pkg::SERVICES_PER_RULE_DEF,
  parameter int APPS_PER_RULE     = fmrc_pkg::APPS_PER_RULE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_rule_slot,
  input  logic [1:0]  in_list_slot,
  input  logic [1:0]  in_from_zone,
  input  logic [1:0]  in_to_zone,
  input  logic [7:0]  in_protocol,
  input  logic [15:0] in_dest_port,
  input  logic [7:0]  in_app_id,
  input  logic [1:0]  in_rule_verdict,
  input  logic [2:0]  in_service_count,
  input  logic [2:0]  in_app_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_verdict,
  output logic [3:0]  out_matched_rule,
  output logic        out_no_match
);

  localparam int S      = SERVICES_PER_RULE;
  localparam int A      = APPS_PER_RULE;
  localparam int K      = (S > A) ? S : A;
  localparam int RW     = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
  localparam int NW     = $clog2(RULE_DEPTH + 1);
  localparam int KW     = (K > 1) ? $clog2(K) : 1;
  localparam int SDEPTH = RULE_DEPTH * S;
  localparam int ADEPTH = RULE_DEPTH * A;
  localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int AAW    = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;

  fmrc_pkg::state_t state_r, state_nxt;

  logic [4:0]    rule_count_r;
  logic [NW-1:0] scan_n;

  logic [1:0]  sess_from_r, sess_to_r;
  logic [7:0]  sess_proto_r;
  logic [15:0] sess_port_r;
  logic [7:0]  sess_app_r;

  logic          iss_active_r, iss_active_nxt;
  logic [RW-1:0] iss_rule_r, iss_rule_nxt;
  logic [KW-1:0] iss_slot_r, iss_slot_nxt;
  logic          d_valid_r, d_valid_nxt;
  logic [RW-1:0] d_rule_r;
  logic [KW-1:0] d_slot_r;
  logic          svc_acc_r, svc_acc_nxt;
  logic          app_acc_r, app_acc_nxt;

  logic [1:0] pend_verdict_r, pend_verdict_nxt;
  logic [3:0] pend_rule_r, pend_rule_nxt;
  logic       pend_nomatch_r, pend_nomatch_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_verdict_r;
  logic [3:0] out_rule_r;
  logic       out_nomatch_r;
  logic       out_load;

  logic in_acc;
  logic is_eval, hdr_we, svc_we, app_we;
  logic rs_ok;

  fmrc_pkg::hdr_t hdr_wdata, hdr_rd;
  fmrc_pkg::svc_t svc_wdata, svc_rd;
  logic [7:0]     app_rd;
  logic [1:0]     verd_sat;
  logic [2:0]     sc_sat, ac_sat;

  logic [SAW-1:0] svc_waddr, svc_raddr;
  logic [AAW-1:0] app_waddr, app_raddr;
  logic [31:0]    svc_rslot, app_rslot;

  logic iss_last_slot, iss_last_rule;
  logic d_last_slot, d_last_rule;
  logic zone_ok, svc_hit_k, app_hit_k, svc_any, app_any, rule_hit;
  logic fin;

  // Request decode
  assign in_stall = (state_r != fmrc_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign rs_ok    = (32'(in_rule_slot) < RULE_DEPTH);

  always_comb begin
    is_eval = 1'b0;
    hdr_we  = 1'b0;
    svc_we  = 1'b0;
    app_we  = 1'b0;
    unique case (fmrc_pkg::act_t'(in_action))
      fmrc_pkg::ACT_EVAL: is_eval = in_acc;
      fmrc_pkg::ACT_HDR:  hdr_we  = in_acc && rs_ok;
      fmrc_pkg::ACT_SVC:  svc_we  = in_acc && rs_ok && (32'(in_list_slot) < S);
      fmrc_pkg::ACT_APP:  app_we  = in_acc && rs_ok && (32'(in_list_slot) < A);
      default: ;
    endcase
  end

  assign verd_sat = (in_rule_verdict > fmrc_pkg::VERD_DROP) ? fmrc_pkg::VERD_DROP
                                                             : in_rule_verdict;
  assign sc_sat   = (32'(in_service_count) > S) ? 3'(S) : in_service_count;
  assign ac_sat   = (32'(in_app_count) > A) ? 3'(A) : in_app_count;

  always_comb begin
    hdr_wdata.from_zone = in_from_zone;
    hdr_wdata.to_zone   = in_to_zone;
    hdr_wdata.verdict   = verd_sat;
    hdr_wdata.svc_count = sc_sat;
    hdr_wdata.app_count = ac_sat;
    svc_wdata.proto     = in_protocol;
    svc_wdata.port      = in_dest_port;
  end

  assign svc_waddr = SAW'(32'(in_rule_slot) * S + 32'(in_list_slot));
  assign app_waddr = AAW'(32'(in_rule_slot) * A + 32'(in_list_slot));

  // Read addresses follow the issue pointer
  assign svc_rslot = (32'(iss_slot_r) < S) ? 32'(iss_slot_r) : 32'd0;
  assign app_rslot = (32'(iss_slot_r) < A) ? 32'(iss_slot_r) : 32'd0;
  assign svc_raddr = SAW'(32'(iss_rule_r) * S + svc_rslot);
  assign app_raddr = AAW'(32'(iss_rule_r) * A + app_rslot);

  fmrc_ram #(.WIDTH($bits(fmrc_pkg::hdr_t)), .DEPTH(RULE_DEPTH)) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (RW'(in_rule_slot)),
    .wdata (hdr_wdata),
    .raddr (iss_rule_r),
    .rdata (hdr_rd)
  );

  fmrc_ram #(.WIDTH($bits(fmrc_pkg::svc_t)), .DEPTH(SDEPTH)) u_svc_ram (
    .clk   (clk),
    .we    (svc_we),
    .waddr (svc_waddr),
    .wdata (svc_wdata),
    .raddr (svc_raddr),
    .rdata (svc_rd)
  );

  fmrc_ram #(.WIDTH(8), .DEPTH(ADEPTH)) u_app_ram (
    .clk   (clk),
    .we    (app_we),
    .waddr (app_waddr),
    .wdata (in_app_id),
    .raddr (app_raddr),
    .rdata (app_rd)
  );

  // Scan length
  assign scan_n = (32'(rule_count_r) > RULE_DEPTH) ? NW'(RULE_DEPTH) : NW'(rule_count_r);

  assign iss_last_slot = (32'(iss_slot_r) == K - 1);
  assign iss_last_rule = ((NW'(iss_rule_r) + NW'(1)) == scan_n);
  assign d_last_slot   = (32'(d_slot_r) == K - 1);
  assign d_last_rule   = ((NW'(d_rule_r) + NW'(1)) == scan_n);

  // Shared compare unit: one service slot and one application slot per cycle
  assign zone_ok = ((hdr_rd.from_zone == fmrc_pkg::ZONE_ANY) ||
                    (hdr_rd.from_zone == sess_from_r)) &&
                   ((hdr_rd.to_zone == fmrc_pkg::ZONE_ANY) ||
                    (hdr_rd.to_zone == sess_to_r));

  assign svc_hit_k = (32'(d_slot_r) < S) && (32'(d_slot_r) < 32'(hdr_rd.svc_count)) &&
                     ((svc_rd.proto == 8'd0) || (svc_rd.proto == sess_proto_r)) &&
                     ((svc_rd.port == 16'd0) || (svc_rd.port == sess_port_r));
  assign app_hit_k = (32'(d_slot_r) < A) && (32'(d_slot_r) < 32'(hdr_rd.app_count)) &&
                     (app_rd == sess_app_r);

  assign svc_any = svc_hit_k || ((d_slot_r != '0) && svc_acc_r);
  assign app_any = app_hit_k || ((d_slot_r != '0) && app_acc_r);

  assign rule_hit = zone_ok &&
                    ((hdr_rd.svc_count == 3'd0) || svc_any) &&
                    ((hdr_rd.app_count == 3'd0) || (sess_app_r == 8'd0) || app_any);

  assign svc_acc_nxt = svc_any;
  assign app_acc_nxt = app_any;

  assign out_load = !out_valid_r || !out_stall;

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    iss_active_nxt   = iss_active_r;
    iss_rule_nxt     = iss_rule_r;
    iss_slot_nxt     = iss_slot_r;
    d_valid_nxt      = 1'b0;
    pend_verdict_nxt = pend_verdict_r;
    pend_rule_nxt    = pend_rule_r;
    pend_nomatch_nxt = pend_nomatch_r;
    out_valid_nxt    = out_valid_r && out_stall;
    fin              = 1'b0;
    unique case (state_r)
      fmrc_pkg::ST_IDLE: begin
        if (is_eval) begin
          state_nxt      = fmrc_pkg::ST_SCAN;
          iss_active_nxt = 1'b1;
          iss_rule_nxt   = '0;
          iss_slot_nxt   = '0;
        end
      end
      fmrc_pkg::ST_SCAN: begin
        if (scan_n == '0) begin
          fin              = 1'b1;
          pend_verdict_nxt = fmrc_pkg::VERD_DENY;
          pend_rule_nxt    = 4'd0;
          pend_nomatch_nxt = 1'b1;
        end else if (d_valid_r && d_last_slot && rule_hit) begin
          fin              = 1'b1;
          pend_verdict_nxt = hdr_rd.verdict;
          pend_rule_nxt    = 4'(d_rule_r);
          pend_nomatch_nxt = 1'b0;
        end else if (d_valid_r && d_last_slot && d_last_rule) begin
          fin              = 1'b1;
          pend_verdict_nxt = fmrc_pkg::VERD_DENY;
          pend_rule_nxt    = 4'd0;
          pend_nomatch_nxt = 1'b1;
        end
        if (fin) begin
          state_nxt      = fmrc_pkg::ST_HOLD;
          iss_active_nxt = 1'b0;
        end else if (iss_active_r) begin
          d_valid_nxt = 1'b1;
          if (iss_last_slot) begin
            iss_slot_nxt = '0;
            iss_rule_nxt = iss_rule_r + RW'(1);
            if (iss_last_rule) begin
              iss_active_nxt = 1'b0;
            end
          end else begin
            iss_slot_nxt = iss_slot_r + KW'(1);
          end
        end
      end
      fmrc_pkg::ST_HOLD: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = fmrc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fmrc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fmrc_pkg::ST_IDLE;
      rule_count_r <= 5'd0;
      iss_active_r <= 1'b0;
      d_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      iss_active_r <= iss_active_nxt;
      d_valid_r    <= d_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        rule_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_rule_r     <= iss_rule_nxt;
    iss_slot_r     <= iss_slot_nxt;
    d_rule_r       <= iss_rule_r;
    d_slot_r       <= iss_slot_r;
    svc_acc_r      <= svc_acc_nxt;
    app_acc_r      <= app_acc_nxt;
    pend_verdict_r <= pend_verdict_nxt;
    pend_rule_r    <= pend_rule_nxt;
    pend_nomatch_r <= pend_nomatch_nxt;
    if (is_eval) begin
      sess_from_r  <= in_from_zone;
      sess_to_r    <= in_to_zone;
      sess_proto_r <= in_protocol;
      sess_port_r  <= in_dest_port;
      sess_app_r   <= in_app_id;
    end
    if ((state_r == fmrc_pkg::ST_HOLD) && out_load) begin
      out_verdict_r <= pend_verdict_r;
      out_rule_r    <= pend_rule_r;
      out_nomatch_r <= pend_nomatch_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = out_verdict_r;
  assign out_matched_rule = out_rule_r;
  assign out_no_match     = out_nomatch_r;

  a_load_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == fmrc_pkg::ST_HOLD))
    else $error("result loaded outside hold state");

  a_nomatch_deny: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_nomatch_r) |-> ((out_verdict_r == fmrc_pkg::VERD_DENY) &&
                                        (out_rule_r == 4'd0)))
    else $error("no-match result is not a default deny");

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (iss_active_r && (state_r == fmrc_pkg::ST_SCAN) && (scan_n != '0)) |->
      (NW'(iss_rule_r) < scan_n))
    else $error("scan issued beyond rule count");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_verdict_r != 2'd3))
    else $error("invalid verdict code on output");

endmodule
